### src/crc16_pkg.sv
// Package: widths, register indexes, reset values and the CRC update function.
`default_nettype none

package crc16_pkg;

    localparam int CRC_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLYNOMIAL     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_INVERT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FINAL_INVERT   = 2'd2;

    localparam logic [CRC_W-1:0]   POLY_RESET = 16'h1021;
    localparam logic [CRC_W-1:0]   CRC_ONES   = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_FULL = 4'd8;

    typedef logic [CRC_W-1:0] crc_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] bit_count;
        logic               start_message;
        logic               end_message;
    } in_word_t;

    // Shift the leading bits of a byte into the CRC, MSB first.
    function automatic crc_t crc_update(
        input crc_t               crc,
        input logic [BYTE_W-1:0]  data,
        input logic [COUNT_W-1:0] count,
        input crc_t               poly
    );
        crc_t               c;
        logic [COUNT_W-1:0] n;
        logic               fb;
        c = crc;
        n = count[COUNT_W-1] ? COUNT_FULL : count;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (COUNT_W'(i) < n)
            begin
                fb = c[CRC_W-1] ^ data[BYTE_W-1-i];
                c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? poly : '0);
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/crc16_if.sv
// Interfaces: input word channel and checksum channel.
`default_nettype none

interface crc16_in_if;
    import crc16_pkg::*;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] bit_count;
    logic               start_message;
    logic               end_message;

    modport source (output valid, data_byte, bit_count, start_message, end_message,
                    input ready);
    modport sink   (input valid, data_byte, bit_count, start_message, end_message,
                    output ready);
endinterface

interface crc16_out_if;
    import crc16_pkg::*;
    logic             valid;
    logic             ready;
    logic [CRC_W-1:0] checksum;

    modport source (output valid, checksum, input ready);
    modport sink   (input valid, checksum, output ready);
endinterface

`default_nettype wire

### src/crc16_configurable_engine.sv
// Top level: configurable MSB-first CRC-16 engine with registered input and result.
//
// Takes one word per cycle: a byte with a count of its leading bits to shift in,
// plus start and end flags. Start reloads the CRC with 0 or 0xFFFF (start-at-ones
// flag) before the byte; end emits the CRC after the byte, XORed with 0xFFFF when
// the output-complement flag is set. A word passes an input register, then an unrolled
// eight-bit shift against the running CRC register writes the result register.
// Sustained rate is one word per cycle, set by the combinational byte update of the
// running CRC; it stalls only while an end word finds the result register full and not
// being taken.
// Configuration is written through cfg_write_en, cfg_index (0 polynomial,
// 1 start-at-ones flag, 2 output-complement flag) and cfg_data; other indexes are ignored.
`default_nettype none

module crc16_configurable_engine
    import crc16_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    crc16_in_if.sink                    in_word,
    crc16_out_if.source                 out_word,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    crc_t     poly_reg;
    logic     init_inv_reg;
    logic     final_inv_reg;

    in_word_t word_reg;
    logic     word_valid_reg;
    crc_t     crc_reg;
    crc_t     crc_next;
    crc_t     crc_base;
    crc_t     sum_reg;
    logic     sum_valid_reg;

    logic     advance;
    logic     in_take;

    assign advance = word_valid_reg
                     && (!word_reg.end_message || !sum_valid_reg || out_word.ready);
    assign in_word.ready = !word_valid_reg || advance;
    assign in_take = in_word.valid && in_word.ready;

    assign crc_base = word_reg.start_message ? (init_inv_reg ? CRC_ONES : '0) : crc_reg;
    assign crc_next = crc_update(crc_base, word_reg.data_byte, word_reg.bit_count, poly_reg);

    assign out_word.valid    = sum_valid_reg;
    assign out_word.checksum = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= POLY_RESET;
            init_inv_reg  <= 1'b1;
            final_inv_reg <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_POLYNOMIAL:     poly_reg      <= cfg_data[CRC_W-1:0];
                CFG_INITIAL_INVERT: init_inv_reg  <= cfg_data[0];
                CFG_FINAL_INVERT:   final_inv_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            crc_reg        <= '0;
        end
        else
        begin
            if (in_word.ready)
            begin
                word_valid_reg <= in_take;
            end
            if (advance)
            begin
                crc_reg <= crc_next;
            end
            if (advance && word_reg.end_message)
            begin
                sum_valid_reg <= 1'b1;
            end
            else if (out_word.ready)
            begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg.data_byte     <= in_word.data_byte;
            word_reg.bit_count     <= in_word.bit_count;
            word_reg.start_message <= in_word.start_message;
            word_reg.end_message   <= in_word.end_message;
        end
        if (advance && word_reg.end_message)
        begin
            sum_reg <= crc_next ^ (final_inv_reg ? CRC_ONES : '0);
        end
    end

endmodule

`default_nettype wire
